### sv/swm_pkg.sv
// ----------------------------------------------------------------------------
// swm_pkg: shared types and constants of the sliding window maximum
// Sizes of the cell chain, widths of the word fields and the control word
// that the controller broadcasts along the chain.
// ----------------------------------------------------------------------------
package swm_pkg;

  // depth of the chain, one cell per possible window slot
  localparam int WINDOW_MAX = 256;
  // positions wrap at this count
  localparam int FRAME_MAX  = 65536;

  localparam int DATA_W = 32;
  localparam int CFG_W  = 9;
  localparam int IDX_W  = $clog2(WINDOW_MAX);
  localparam int LEN_W  = $clog2(WINDOW_MAX) + 1;
  localparam int POS_W  = $clog2(FRAME_MAX);

  typedef logic [IDX_W-1:0]         idx_t;
  typedef logic signed [DATA_W-1:0] data_t;

  // control word seen by every cell in the chain
  typedef struct packed {
    logic               step;    // a new word enters the chain
    logic               grow;    // window longer: move contents one cell down
    logic               shrink;  // window shorter: move contents one cell up
    logic [IDX_W-1:0]   head;    // cell that holds the newest sample
    logic signed [DATA_W-1:0] sample;
  } bcast_t;

  // larger of two signed values
  function automatic data_t max_signed(input data_t a, input data_t b);
    return (a > b) ? a : b;
  endfunction

endpackage

### sv/swm_cell.sv
// ----------------------------------------------------------------------------
// swm_cell: one slot of the running maximum chain
// Holds the maximum of the live samples up to its age. On a new word it
// takes the sample or the larger of the sample and its lower neighbour;
// while the window length is realigned it moves one cell up or down.
// ----------------------------------------------------------------------------
module swm_cell (
  input  logic                clk,
  input  swm_pkg::idx_t       idx,
  input  swm_pkg::bcast_t     bcast,
  input  swm_pkg::data_t      lower,
  input  swm_pkg::data_t      upper,
  output swm_pkg::data_t      value
);

  // cells below the head are outside the window and hold on a new word
  always_ff @(posedge clk) begin
    if (bcast.step) begin
      if (idx == bcast.head) begin
        value <= bcast.sample;
      end else if (idx > bcast.head) begin
        value <= swm_pkg::max_signed(bcast.sample, lower);
      end
    end else if (bcast.grow) begin
      value <= upper;
    end else if (bcast.shrink) begin
      value <= lower;
    end
  end

endmodule

### sv/swm_ctrl.sv
// ----------------------------------------------------------------------------
// swm_ctrl: handshake, window length and position control
// Keeps the window length register, the head index of the chain, the frame
// position and the output register, and drives the chain's control word.
// ----------------------------------------------------------------------------
module swm_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [swm_pkg::CFG_W-1:0]   cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  swm_pkg::data_t              sample,
  input  logic                        frame_end,
  input  swm_pkg::data_t              tail_value,
  output swm_pkg::bcast_t             bcast,
  output logic                        out_valid,
  input  logic                        out_stall,
  output swm_pkg::data_t              window_max,
  output logic [swm_pkg::POS_W-1:0]   window_start,
  output logic                        last
);

  logic [swm_pkg::CFG_W-1:0] window_len;
  swm_pkg::idx_t             head;
  logic [swm_pkg::POS_W-1:0] position;

  logic [swm_pkg::LEN_W-1:0] eff_len;
  logic [swm_pkg::LEN_W-1:0] cur_len;
  swm_pkg::idx_t             head_target;
  logic                      misaligned;
  logic                      accept;
  logic                      full;
  swm_pkg::data_t            top_next;
  logic [swm_pkg::POS_W-1:0] start_pos;

  // clamp the programmed length to 1..WINDOW_MAX
  always_comb begin
    if (int'(window_len) > swm_pkg::WINDOW_MAX) begin
      eff_len = swm_pkg::LEN_W'(swm_pkg::WINDOW_MAX);
    end else if (window_len == '0) begin
      eff_len = swm_pkg::LEN_W'(1);
    end else begin
      eff_len = swm_pkg::LEN_W'(window_len);
    end
  end

  // head index the chain has to sit at for this length
  assign head_target = swm_pkg::IDX_W'(swm_pkg::WINDOW_MAX - int'(eff_len));
  assign misaligned  = (head != head_target);
  assign cur_len     = swm_pkg::LEN_W'(swm_pkg::WINDOW_MAX - int'(head));

  // handshake: hold off while realigning or while the result slot is blocked
  assign in_stall = misaligned || (out_valid && out_stall);
  assign accept   = in_valid && !in_stall;

  // window full once the position reaches length - 1
  assign full      = (int'(position) + 1) >= int'(cur_len);
  assign start_pos = swm_pkg::POS_W'(int'(position) + 1 - int'(cur_len));

  // value the last cell takes on this word: the window maximum
  assign top_next = (head == swm_pkg::IDX_W'(swm_pkg::WINDOW_MAX - 1)) ? sample
                  : swm_pkg::max_signed(sample, tail_value);

  // control word for the chain
  always_comb begin
    bcast.step   = accept;
    bcast.grow   = misaligned && (head_target < head);
    bcast.shrink = misaligned && (head_target > head);
    bcast.head   = head;
    bcast.sample = sample;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      window_len <= swm_pkg::CFG_W'(1);
      head       <= swm_pkg::IDX_W'(swm_pkg::WINDOW_MAX - 1);
      position   <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        window_len <= cfg_data;
      end
      if (bcast.grow) begin
        head <= head - swm_pkg::IDX_W'(1);
      end else if (bcast.shrink) begin
        head <= head + swm_pkg::IDX_W'(1);
      end
      if (accept) begin
        position <= frame_end ? '0 : position + swm_pkg::POS_W'(1);
      end
      if (accept) begin
        out_valid <= full;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // output word
  always_ff @(posedge clk) begin
    if (accept && full) begin
      window_max   <= top_next;
      window_start <= start_pos;
      last         <= frame_end;
    end
  end

endmodule

### sv/sliding_window_maximum.sv
// ----------------------------------------------------------------------------
// sliding_window_maximum: running maximum over the last window_len samples
// A chain of cells holds, per sample age, the maximum of the live samples;
// the last cell carries the window maximum for each result word.
// ----------------------------------------------------------------------------
// One sample word is accepted per clock while the chain is aligned and the
// result word is taken; its result is written into the output register by
// the clock that accepts it, and the chain of cells updates all slots in
// that same clock. After window_len is written the chain realigns to the
// new length by one cell per clock and holds the input off until it has
// moved |new length - old length| cells (at most 255). No result is given
// until a frame holds window_len samples, and frame_end clears the position.
module sliding_window_maximum (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [swm_pkg::CFG_W-1:0]   cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [31:0]          sample,
  input  logic                        frame_end,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [31:0]          window_max,
  output logic [15:0]                 window_start,
  output logic                        last
);

  swm_pkg::bcast_t bcast;
  swm_pkg::data_t  cell_value [swm_pkg::WINDOW_MAX];

  // controller
  swm_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .sample       (sample),
    .frame_end    (frame_end),
    .tail_value   (cell_value[swm_pkg::WINDOW_MAX-2]),
    .bcast        (bcast),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .window_max   (window_max),
    .window_start (window_start),
    .last         (last)
  );

  // chain of cells, oldest slot at the top end
  for (genvar i = 0; i < swm_pkg::WINDOW_MAX; i++) begin : g_cell
    if (i == 0) begin : g_bottom
      swm_cell u_cell (
        .clk   (clk),
        .idx   (swm_pkg::IDX_W'(i)),
        .bcast (bcast),
        .lower ('0),
        .upper (cell_value[i+1]),
        .value (cell_value[i])
      );
    end else if (i == swm_pkg::WINDOW_MAX - 1) begin : g_top
      swm_cell u_cell (
        .clk   (clk),
        .idx   (swm_pkg::IDX_W'(i)),
        .bcast (bcast),
        .lower (cell_value[i-1]),
        .upper (cell_value[i]),
        .value (cell_value[i])
      );
    end else begin : g_mid
      swm_cell u_cell (
        .clk   (clk),
        .idx   (swm_pkg::IDX_W'(i)),
        .bcast (bcast),
        .lower (cell_value[i-1]),
        .upper (cell_value[i+1]),
        .value (cell_value[i])
      );
    end
  end

endmodule

### bench/sliding_window_maximum_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_maximum_tb: self-checking bench for the sliding window maximum
// Streams sample words in frames under many window lengths: short and longest
// windows, zero and oversized lengths and changes inside a frame. A local
// candidate-queue predictor works out each window maximum. Every result word
// is checked field by field, with both handshakes idling and stalling at random in part of the run.
// ----------------------------------------------------------------------------
module sliding_window_maximum_tb;

  localparam int CLK_PERIOD    = 8;
  localparam int IDLE_LIMIT    = 5000;
  localparam int SETTLE_CYCLES = 4;

  typedef struct {
    swm_pkg::data_t max_val;
    logic [15:0]    start;
    logic           last;
  } max_word_t;

  typedef struct {
    swm_pkg::data_t val;
    int             pos;
  } candidate_t;

  logic                      clk;
  logic                      rst;
  logic                      cfg_we;
  logic [swm_pkg::CFG_W-1:0] cfg_data;
  logic                      in_valid;
  logic                      in_stall;
  swm_pkg::data_t            sample;
  logic                      frame_end;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  swm_pkg::data_t            window_max;
  logic [15:0]               window_start;
  logic                      last;

  // predictor state
  max_word_t      expected_maxima[$];
  candidate_t     candidates[$];
  int             frame_pos  = 0;
  int             cur_window = 1;
  swm_pkg::data_t ramp_val   = '0;

  // idling and bookkeeping
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int errors         = 0;
  int words_sent     = 0;
  int maxima_checked = 0;
  int frames_closed  = 0;
  int cfg_writes     = 0;
  int idle_cycles    = 0;

  sliding_window_maximum dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .sample       (sample),
    .frame_end    (frame_end),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .window_max   (window_max),
    .window_start (window_start),
    .last         (last)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // monotonic candidate queue: expected result word for one accepted sample
  function automatic void predict_maximum(input swm_pkg::data_t s, input logic fe);
    int         age;
    candidate_t c;
    max_word_t  m;
    // smaller candidates can never be the maximum again
    while (candidates.size() > 0 && s > candidates[$].val)
      candidates.delete(candidates.size() - 1);
    // drop candidates that have slid out of the window, modulo the frame size
    while (candidates.size() > 0) begin
      age = (frame_pos >= candidates[0].pos)
          ? frame_pos - candidates[0].pos
          : frame_pos + swm_pkg::FRAME_MAX - candidates[0].pos;
      if (age < cur_window) break;
      candidates.delete(0);
    end
    if (candidates.size() < swm_pkg::WINDOW_MAX) begin
      c.val = s;
      c.pos = frame_pos;
      candidates.insert(candidates.size(), c);
    end
    // a result only once the window is full
    if (frame_pos + 1 >= cur_window) begin
      m.max_val = candidates[0].val;
      m.start   = 16'(frame_pos + 1 - cur_window);
      m.last    = fe;
      expected_maxima.insert(expected_maxima.size(), m);
    end
    if (fe) begin
      candidates.delete();
      frame_pos = 0;
      frames_closed++;
    end else begin
      frame_pos = (frame_pos + 1 >= swm_pkg::FRAME_MAX) ? 0 : frame_pos + 1;
    end
  endfunction

  // mix of extremes, small values with ties, falling runs and full range
  function automatic swm_pkg::data_t pick_sample();
    case ($urandom_range(0, 9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2, 3, 4: return swm_pkg::data_t'($urandom_range(0, 15)) - 8;
      5, 6: begin
        ramp_val = ramp_val - swm_pkg::data_t'($urandom_range(0, 3));
        return ramp_val;
      end
      default: return swm_pkg::data_t'($urandom);
    endcase
  endfunction

  function automatic void set_idling(input int send_pct, input int stall_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
  endfunction

  // send one sample word, with a random idle gap before it
  task automatic send_word(input swm_pkg::data_t s, input logic fe);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    sample    <= s;
    frame_end <= fe;
    do @(posedge clk); while (in_stall !== 1'b0);
    predict_maximum(s, fe);
    words_sent++;
  endtask

  // hold the sender off until every expected result has been taken
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_maxima.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // window length write, only with the block idle
  task automatic set_window(input int len);
    int wl;
    wait_drained();
    wl = len & 'h1FF;
    cfg_we   <= 1'b1;
    cfg_data <= swm_pkg::CFG_W'(wl);
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_window = (wl == 0) ? 1 : (wl > swm_pkg::WINDOW_MAX) ? swm_pkg::WINDOW_MAX : wl;
    cfg_writes++;
  endtask

  // field extremes, ties, short frames, zero length and changes inside a frame
  task automatic test_directed();
    set_idling(0, 0);
    // reset length of one: every word is its own maximum
    send_word(32'h7FFF_FFFF, 1'b0);
    send_word(32'h8000_0000, 1'b0);
    send_word(0, 1'b0);
    send_word(-1, 1'b1);
    // length three with equal values and a falling run
    set_window(3);
    send_word(-5, 1'b0);
    send_word(7, 1'b0);
    send_word(7, 1'b0);
    send_word(3, 1'b0);
    send_word(2, 1'b1);
    // frame closed before the window fills: no result, state still clears
    send_word(1, 1'b0);
    send_word(2, 1'b1);
    // zero length behaves as one
    set_window(0);
    send_word(10, 1'b0);
    send_word(20, 1'b1);
    // length shortened then lengthened inside one frame
    set_window(4);
    send_word(9, 1'b0);
    send_word(1, 1'b0);
    send_word(2, 1'b0);
    send_word(3, 1'b0);
    set_window(2);
    send_word(1, 1'b0);
    send_word(0, 1'b0);
    set_window(5);
    send_word(8, 1'b0);
    send_word(7, 1'b1);
  endtask

  // oversized length saturates, then the longest window written directly
  task automatic test_window_limits();
    int i;
    set_idling(29, 29);
    set_window(511);
    ramp_val = swm_pkg::data_t'($urandom);
    for (i = 0; i < swm_pkg::WINDOW_MAX / 2; i++)
      send_word(pick_sample(), 1'b0);
    // same effective length inside the frame, so nothing realigns
    set_window(swm_pkg::WINDOW_MAX);
    for (i = 0; i < swm_pkg::WINDOW_MAX / 2 + 20; i++)
      send_word(pick_sample(), i == swm_pkg::WINDOW_MAX / 2 + 19);
  endtask

  // random frames under random lengths, mostly long enough to give results
  task automatic test_random_frames(input int n_words);
    int sent, frame_len, split, i, r;
    sent = 0;
    while (sent < n_words) begin
      case ((sent * 4) / n_words)
        0:       set_idling(0, 0);
        1:       set_idling(72, 0);
        2:       set_idling(0, 72);
        default: set_idling(29, 29);
      endcase
      // new length at most frame starts, otherwise frames run back to back
      if ($urandom_range(0, 4) < 3) begin
        r = $urandom_range(0, 19);
        if (r < 13)      set_window($urandom_range(1, 8));
        else if (r < 19) set_window($urandom_range(9, 40));
        else             set_window(0);
      end else if ($urandom_range(0, 7) == 0) begin
        wait_drained();
      end
      // a fifth of the frames close before or just as the window fills
      frame_len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, cur_window)
                                              : cur_window + $urandom_range(0, 30);
      split = ($urandom_range(0, 4) == 0 && frame_len > 1)
            ? $urandom_range(1, frame_len - 1) : 0;
      ramp_val = swm_pkg::data_t'($urandom);
      for (i = 0; i < frame_len; i++) begin
        if (split != 0 && i == split) set_window($urandom_range(1, 12));
        send_word(pick_sample(), i == frame_len - 1);
      end
      sent += frame_len;
    end
  endtask

  // receiver stalls and result word check
  always @(posedge clk) begin : check_results
    max_word_t exp_w;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      if (out_valid && !out_stall) begin
        maxima_checked++;
        if (expected_maxima.size() == 0) begin
          $error("unexpected result word: window_max %0d window_start %0d last %0b",
                 window_max, window_start, last);
          errors++;
        end else begin
          exp_w = expected_maxima[0];
          expected_maxima.delete(0);
          if (window_max !== exp_w.max_val) begin
            $error("window_max: expected %0d, got %0d", exp_w.max_val, window_max);
            errors++;
          end
          if (window_start !== exp_w.start) begin
            $error("window_start: expected %0d, got %0d", exp_w.start, window_start);
            errors++;
          end
          if (last !== exp_w.last) begin
            $error("last: expected %0b, got %0b", exp_w.last, last);
            errors++;
          end
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("[sliding_window_maximum] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // test sequence
  initial begin
    rst       <= 1'b1;
    cfg_we    <= 1'b0;
    cfg_data  <= '0;
    in_valid  <= 1'b0;
    sample    <= '0;
    frame_end <= 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_window_limits();
    test_random_frames(350);

    // let the last results out
    wait_drained();
    repeat (10) @(posedge clk);
    $display("run covered %0d sample words in %0d frames, %0d result words checked",
             words_sent, frames_closed, maxima_checked);
    $display("window writes: %0d, lengths zero to oversized, changes inside frames",
             cfg_writes);
    if (errors == 0) $display("[sliding_window_maximum] OK");
    else $display("[sliding_window_maximum] ERROR");
    $finish;
  end

endmodule
